// ----- hw/rtl/mlcd_pkg.sv -----
// Shared types, constants and the CRC-8 step for the frame deframer.
package mlcd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned POS_W   = 17;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [BYTE_W-1:0] MAGIC_BYTE = 8'hC8;
	localparam logic [BYTE_W-1:0] CRC_POLY   = 8'h07;
	localparam logic [BYTE_W-1:0] CRC_TOPBIT = 8'h80;
	localparam logic [POS_W-1:0]  HEADER_BYTES = 17'd4;
	localparam logic [POS_W-1:0]  POS_COMMAND = 17'd1;
	localparam logic [POS_W-1:0]  POS_LEN_LO  = 17'd2;
	localparam logic [POS_W-1:0]  POS_LEN_HI  = 17'd3;

	localparam logic [CFG_DATA_W-1:0] MAX_PAYLOAD_RESET = 16'd256;
	localparam logic [CFG_DATA_W-1:0] TIMEOUT_RESET     = 16'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_PAYLOAD = 8'd0,
		CFG_TIMEOUT     = 8'd1
	} cfg_index_t;

	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_TICK = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		EV_PAYLOAD = 2'd0,
		EV_GOOD    = 2'd1,
		EV_CRC_ERR = 2'd2,
		EV_LEN_ERR = 2'd3
	} event_t;

	function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] c;
		c = crc ^ b;
		for (int i = 0; i < BYTE_W; i++) begin
			if ((c & CRC_TOPBIT) != '0) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/mlcd_ifs.sv -----
// Channel interfaces for input items, result items and configuration writes.
interface mlcd_in_if;
	logic                              valid;
	logic                              ready;
	mlcd_pkg::kind_t                   kind;
	logic [mlcd_pkg::BYTE_W-1:0]       byte_value;
	modport source (output valid, output kind, output byte_value, input ready);
	modport sink (input valid, input kind, input byte_value, output ready);
endinterface

interface mlcd_out_if;
	logic                              valid;
	logic                              ready;
	mlcd_pkg::event_t                  event_res;
	logic [mlcd_pkg::BYTE_W-1:0]       command_code;
	logic [mlcd_pkg::LEN_W-1:0]        byte_index;
	logic [mlcd_pkg::BYTE_W-1:0]       payload_byte;
	logic [mlcd_pkg::LEN_W-1:0]        payload_length;
	modport source (output valid, output event_res, output command_code, output byte_index,
		output payload_byte, output payload_length, input ready);
	modport sink (input valid, input event_res, input command_code, input byte_index,
		input payload_byte, input payload_length, output ready);
endinterface

interface mlcd_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [mlcd_pkg::CFG_IDX_W-1:0]    index;
	logic [mlcd_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/magic_length_crc8_deframer_unit.sv -----
// Length-prefixed CRC-8 frame deframer: parser state and registered result.
// One input item (received byte or millisecond tick) is taken per clock cycle;
// its result, if any, appears in the output register on the next cycle. The input
// side stalls only while a result is held in that register and the sink is not ready.
// Configuration writes are always taken.
module magic_length_crc8_deframer_unit (
	input  logic           clk,
	input  logic           arst_n,
	mlcd_in_if.sink        rx,
	mlcd_out_if.source     evt,
	mlcd_cfg_if.sink       cfg
);

	logic [mlcd_pkg::CFG_DATA_W-1:0] max_payload_q;
	logic [mlcd_pkg::CFG_DATA_W-1:0] timeout_q;

	logic [mlcd_pkg::POS_W-1:0]  pos_q, pos_d;
	logic [mlcd_pkg::BYTE_W-1:0] cmd_q, cmd_d;
	logic [mlcd_pkg::LEN_W-1:0]  len_q, len_d;
	logic [mlcd_pkg::BYTE_W-1:0] crc_q, crc_d;
	logic [mlcd_pkg::LEN_W-1:0]  idle_q, idle_d;

	logic                        emit;
	mlcd_pkg::event_t            emit_ev;
	logic [mlcd_pkg::LEN_W-1:0]  emit_idx;
	logic [mlcd_pkg::BYTE_W-1:0] emit_byte;

	logic                        out_valid_q;
	mlcd_pkg::event_t            ev_q;
	logic [mlcd_pkg::BYTE_W-1:0] cmd_out_q;
	logic [mlcd_pkg::LEN_W-1:0]  idx_q;
	logic [mlcd_pkg::BYTE_W-1:0] byte_q;
	logic [mlcd_pkg::LEN_W-1:0]  len_out_q;

	logic                        rx_xfer;
	logic [mlcd_pkg::BYTE_W-1:0] crc_step;
	logic [mlcd_pkg::LEN_W-1:0]  len_full;
	logic [mlcd_pkg::POS_W-1:0]  frame_end;
	logic [mlcd_pkg::POS_W-1:0]  pay_idx;

	assign rx.ready  = !out_valid_q || evt.ready;
	assign rx_xfer   = rx.valid && rx.ready;
	assign cfg.ready = 1'b1;

	assign crc_step  = mlcd_pkg::crc8_update(crc_q, rx.byte_value);
	assign len_full  = {rx.byte_value, len_q[mlcd_pkg::BYTE_W-1:0]};
	assign frame_end = mlcd_pkg::HEADER_BYTES + {1'b0, len_q};
	assign pay_idx   = pos_q - mlcd_pkg::HEADER_BYTES;

	always_comb begin
		pos_d     = pos_q;
		cmd_d     = cmd_q;
		len_d     = len_q;
		crc_d     = crc_q;
		idle_d    = idle_q;
		emit      = 1'b0;
		emit_ev   = mlcd_pkg::EV_PAYLOAD;
		emit_idx  = '0;
		emit_byte = '0;
		if (rx.kind == mlcd_pkg::KIND_TICK) begin
			if (pos_q != '0) begin
				if (idle_q >= timeout_q) begin
					pos_d  = '0;
					idle_d = '0;
				end else begin
					idle_d = idle_q + 1'b1;
				end
			end
		end else if (pos_q == '0) begin
			if (rx.byte_value == mlcd_pkg::MAGIC_BYTE) begin
				pos_d  = mlcd_pkg::POS_COMMAND;
				crc_d  = '0;
				idle_d = '0;
			end
		end else begin
			idle_d = '0;
			if (pos_q == mlcd_pkg::POS_COMMAND) begin
				cmd_d = rx.byte_value;
				crc_d = crc_step;
				pos_d = mlcd_pkg::POS_LEN_LO;
			end else if (pos_q == mlcd_pkg::POS_LEN_LO) begin
				len_d = {{(mlcd_pkg::LEN_W-mlcd_pkg::BYTE_W){1'b0}}, rx.byte_value};
				crc_d = crc_step;
				pos_d = mlcd_pkg::POS_LEN_HI;
			end else if (pos_q == mlcd_pkg::POS_LEN_HI) begin
				len_d = len_full;
				crc_d = crc_step;
				if (len_full > max_payload_q) begin
					pos_d   = '0;
					emit    = 1'b1;
					emit_ev = mlcd_pkg::EV_LEN_ERR;
				end else begin
					pos_d = mlcd_pkg::HEADER_BYTES;
				end
			end else if (pos_q < frame_end) begin
				crc_d     = crc_step;
				pos_d     = pos_q + 1'b1;
				emit      = 1'b1;
				emit_ev   = mlcd_pkg::EV_PAYLOAD;
				emit_idx  = pay_idx[mlcd_pkg::LEN_W-1:0];
				emit_byte = rx.byte_value;
			end else begin
				pos_d   = '0;
				emit    = 1'b1;
				emit_ev = (crc_q == rx.byte_value) ? mlcd_pkg::EV_GOOD : mlcd_pkg::EV_CRC_ERR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= mlcd_pkg::MAX_PAYLOAD_RESET;
			timeout_q     <= mlcd_pkg::TIMEOUT_RESET;
			pos_q         <= '0;
			cmd_q         <= '0;
			len_q         <= '0;
			crc_q         <= '0;
			idle_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					mlcd_pkg::CFG_MAX_PAYLOAD: max_payload_q <= cfg.data;
					mlcd_pkg::CFG_TIMEOUT:     timeout_q     <= cfg.data;
					default: ;
				endcase
			end
			if (rx_xfer) begin
				pos_q       <= pos_d;
				cmd_q       <= cmd_d;
				len_q       <= len_d;
				crc_q       <= crc_d;
				idle_q      <= idle_d;
				out_valid_q <= emit;
			end else if (evt.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_xfer && emit) begin
			ev_q      <= emit_ev;
			cmd_out_q <= cmd_d;
			idx_q     <= emit_idx;
			byte_q    <= emit_byte;
			len_out_q <= len_d;
		end
	end

	assign evt.valid          = out_valid_q;
	assign evt.event_res      = ev_q;
	assign evt.command_code   = cmd_out_q;
	assign evt.byte_index     = idx_q;
	assign evt.payload_byte   = byte_q;
	assign evt.payload_length = len_out_q;

endmodule

// ----- hw/rtl/mlcd_checker.sv -----
// Port-level checker for the deframer and its bind to the top level.
module mlcd_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rx_ready,
	input  logic                              evt_valid,
	input  logic                              evt_ready,
	input  mlcd_pkg::event_t                  evt_event_res,
	input  logic [mlcd_pkg::BYTE_W-1:0]       evt_command_code,
	input  logic [mlcd_pkg::LEN_W-1:0]        evt_byte_index,
	input  logic [mlcd_pkg::BYTE_W-1:0]       evt_payload_byte,
	input  logic [mlcd_pkg::LEN_W-1:0]        evt_payload_length
);

	a_idle_after_reset: assert property (@(posedge clk) !arst_n |-> !evt_valid)
		else $error("result valid during reset");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid && $stable(evt_event_res)
		&& $stable(evt_command_code) && $stable(evt_byte_index)
		&& $stable(evt_payload_byte) && $stable(evt_payload_length))
		else $error("stalled result changed");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!evt_valid |-> rx_ready)
		else $error("input stalled with empty output register");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_event_res == mlcd_pkg::EV_PAYLOAD |->
		evt_byte_index < evt_payload_length)
		else $error("payload index beyond declared length");

	a_status_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_event_res != mlcd_pkg::EV_PAYLOAD |->
		evt_byte_index == '0 && evt_payload_byte == '0)
		else $error("status event carries payload fields");

endmodule

bind magic_length_crc8_deframer_unit mlcd_checker u_mlcd_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.rx_ready           (rx.ready),
	.evt_valid          (evt.valid),
	.evt_ready          (evt.ready),
	.evt_event_res      (evt.event_res),
	.evt_command_code   (evt.command_code),
	.evt_byte_index     (evt.byte_index),
	.evt_payload_byte   (evt.payload_byte),
	.evt_payload_length (evt.payload_length)
);

// ----- tb/magic_length_crc8_deframer_unit_tb.sv -----
// Self-checking testbench for the length-prefixed CRC-8 frame deframer.
module magic_length_crc8_deframer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mlcd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 8'hFF;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		kind_t             kind;
		logic [BYTE_W-1:0] value;
		bit                hold;
	} rx_item_t;

	typedef struct {
		event_t            code;
		logic [BYTE_W-1:0] cmd;
		logic [LEN_W-1:0]  idx;
		logic [BYTE_W-1:0] data;
		logic [LEN_W-1:0]  len;
	} frame_event_t;

	logic clk = 1'b0;
	logic arst_n;

	mlcd_in_if  rx_ch();
	mlcd_out_if evt_ch();
	mlcd_cfg_if cfg_ch();

	magic_length_crc8_deframer_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.evt    (evt_ch),
		.cfg    (cfg_ch)
	);

	rx_item_t     rx_pending[$];
	frame_event_t expected_events[$];
	rx_item_t     next_item;
	frame_event_t got_event;
	frame_event_t want_event;

	int  rx_queued = 0;
	int  rx_accepted = 0;
	int  mismatch_count = 0;
	int  cycle_count = 0;
	int  src_idle_pct = 0;
	int  snk_idle_pct = 0;
	bit  hold_next = 1'b0;
	bit  rx_fired = 1'b0;

	logic [CFG_DATA_W-1:0] cfg_max = MAX_PAYLOAD_RESET;
	logic [CFG_DATA_W-1:0] cfg_tmo = TIMEOUT_RESET;

	logic [POS_W-1:0]  frame_pos = '0;
	logic [BYTE_W-1:0] cmd_hold = '0;
	logic [LEN_W-1:0]  len_hold = '0;
	logic [BYTE_W-1:0] crc_acc = '0;
	logic [LEN_W-1:0]  idle_cnt = '0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [BYTE_W-1:0] crc8_next(input logic [BYTE_W-1:0] acc,
			input logic [BYTE_W-1:0] d);
		logic [BYTE_W-1:0] r;
		r = acc ^ d;
		repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
		return r;
	endfunction

	function automatic bit deframe_step(input kind_t k, input logic [BYTE_W-1:0] b,
			output frame_event_t ev);
		bit               hit;
		logic [POS_W-1:0] p;
		hit = 1'b0;
		p = frame_pos;
		ev.code = EV_PAYLOAD;
		ev.idx = '0;
		ev.data = '0;
		if (k == KIND_TICK) begin
			if (p != '0) begin
				if (idle_cnt >= cfg_tmo) begin
					frame_pos = '0;
					idle_cnt = '0;
				end else begin
					idle_cnt = idle_cnt + 1'b1;
				end
			end
		end else if (p == '0) begin
			if (b == MAGIC_BYTE) begin
				frame_pos = POS_COMMAND;
				crc_acc = '0;
				idle_cnt = '0;
			end
		end else begin
			idle_cnt = '0;
			crc_acc = (p < HEADER_BYTES + len_hold || p < HEADER_BYTES)
				? crc8_next(crc_acc, b) : crc_acc;
			if (p == POS_COMMAND) begin
				cmd_hold = b;
				frame_pos = POS_LEN_LO;
			end else if (p == POS_LEN_LO) begin
				len_hold = {8'h00, b};
				frame_pos = POS_LEN_HI;
			end else if (p == POS_LEN_HI) begin
				len_hold[15:8] = b;
				if (len_hold > cfg_max) begin
					frame_pos = '0;
					hit = 1'b1;
					ev.code = EV_LEN_ERR;
				end else begin
					frame_pos = HEADER_BYTES;
				end
			end else if (p < HEADER_BYTES + len_hold) begin
				frame_pos = p + 1'b1;
				hit = 1'b1;
				ev.code = EV_PAYLOAD;
				ev.idx = LEN_W'(p - HEADER_BYTES);
				ev.data = b;
			end else begin
				frame_pos = '0;
				hit = 1'b1;
				ev.code = (crc_acc == b) ? EV_GOOD : EV_CRC_ERR;
			end
		end
		ev.cmd = cmd_hold;
		ev.len = len_hold;
		return hit;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// sample transfers and score results
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
		if (arst_n) begin
			rx_fired = rx_ch.valid && rx_ch.ready;
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					CFG_MAX_PAYLOAD: cfg_max = cfg_ch.data;
					CFG_TIMEOUT: cfg_tmo = cfg_ch.data;
					default: ;
				endcase
			end
			if (evt_ch.valid && evt_ch.ready) begin
				if (expected_events.size() == 0) begin
					report_mismatch($sformatf("unexpected event %0d cmd %02h",
						evt_ch.event_res, evt_ch.command_code));
				end else begin
					want_event = expected_events.pop_front();
					if (evt_ch.event_res !== want_event.code)
						report_mismatch($sformatf("event got %0d exp %0d",
							evt_ch.event_res, want_event.code));
					if (evt_ch.command_code !== want_event.cmd)
						report_mismatch($sformatf("command got %02h exp %02h",
							evt_ch.command_code, want_event.cmd));
					if (evt_ch.byte_index !== want_event.idx)
						report_mismatch($sformatf("index got %0d exp %0d",
							evt_ch.byte_index, want_event.idx));
					if (evt_ch.payload_byte !== want_event.data)
						report_mismatch($sformatf("payload byte got %02h exp %02h",
							evt_ch.payload_byte, want_event.data));
					if (evt_ch.payload_length !== want_event.len)
						report_mismatch($sformatf("length got %0d exp %0d",
							evt_ch.payload_length, want_event.len));
				end
			end
			if (rx_fired) begin
				rx_accepted++;
				if (deframe_step(rx_ch.kind, rx_ch.byte_value, got_event))
					expected_events.push_back(got_event);
			end
		end
	end

	// hold until transfer, then advance
	always @(negedge clk) begin
		if (!arst_n) begin
			rx_ch.valid <= 1'b0;
		end else if (!rx_ch.valid || rx_fired) begin
			if (rx_pending.size() != 0 && $urandom_range(0, 99) >= src_idle_pct
					&& !(rx_pending[0].hold && expected_events.size() != 0)) begin
				next_item = rx_pending.pop_front();
				rx_ch.valid <= 1'b1;
				rx_ch.kind <= next_item.kind;
				rx_ch.byte_value <= next_item.value;
			end else begin
				rx_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		evt_ch.ready <= arst_n && ($urandom_range(0, 99) >= snk_idle_pct);
	end

	task automatic push_item(input kind_t k, input logic [BYTE_W-1:0] v);
		rx_pending.push_back('{kind: k, value: v, hold: hold_next});
		hold_next = 1'b0;
		rx_queued++;
	endtask

	task automatic push_frame(input logic [BYTE_W-1:0] cmd, input logic [LEN_W-1:0] len,
			input bit crc_ok, input int fill, input int cut, input int gap,
			input int tick_every);
		logic [BYTE_W-1:0] fb[$];
		logic [BYTE_W-1:0] acc;
		logic [BYTE_W-1:0] d;
		int n;
		fb.push_back(MAGIC_BYTE);
		fb.push_back(cmd);
		fb.push_back(len[7:0]);
		fb.push_back(len[15:8]);
		if (len <= cfg_max) begin
			for (int i = 0; i < int'(len); i++) begin
				d = (fill < 0) ? BYTE_W'($urandom) : BYTE_W'(fill);
				fb.push_back((i % 2 == 1) ? ~d : d);
			end
			acc = '0;
			for (int i = 1; i < fb.size(); i++) acc = crc8_next(acc, fb[i]);
			fb.push_back(crc_ok ? acc : acc ^ BYTE_W'($urandom_range(1, 255)));
		end
		n = (cut >= 0 && cut < fb.size()) ? cut : fb.size();
		for (int i = 0; i < n; i++) begin
			if (i > 0 && gap > 0 && tick_every > 0 && $urandom_range(0, tick_every - 1) == 0)
				repeat ($urandom_range(1, gap)) push_item(KIND_TICK, BYTE_W'($urandom));
			push_item(KIND_BYTE, fb[i]);
		end
	endtask

	task automatic push_random(input int count);
		int start;
		int r;
		int sel;
		int cut;
		int gap;
		logic [LEN_W-1:0] len;
		start = rx_queued;
		while (rx_queued - start < count) begin
			if ($urandom_range(0, 49) == 0) hold_next = 1'b1;
			r = $urandom_range(0, 99);
			if (r < 8) begin
				repeat ($urandom_range(1, 3)) push_item(KIND_BYTE, BYTE_W'($urandom));
			end else if (r < 12) begin
				repeat ($urandom_range(1, 3)) push_item(KIND_TICK, BYTE_W'($urandom));
			end else begin
				sel = $urandom_range(0, 99);
				if (sel < 10 && cfg_max != 16'hFFFF)
					len = LEN_W'($urandom_range(int'(cfg_max) + 1, 65535));
				else if (sel < 20)
					len = LEN_W'($urandom_range(0, (cfg_max < 40) ? cfg_max : 40));
				else
					len = LEN_W'($urandom_range(0, (cfg_max < 8) ? cfg_max : 8));
				cut = ($urandom_range(0, 14) == 0) ? $urandom_range(1, 6) : -1;
				gap = (cfg_tmo < 4) ? int'(cfg_tmo) : 4;
				push_frame(BYTE_W'($urandom), len, $urandom_range(0, 9) != 0, -1, cut,
					gap, 8);
				if (cut >= 0 && cfg_tmo <= 8 && $urandom_range(0, 1) == 1)
					repeat (int'(cfg_tmo) + 2) push_item(KIND_TICK, BYTE_W'($urandom));
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		while (rx_accepted != rx_queued || expected_events.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.kind = KIND_BYTE;
		rx_ch.byte_value = '0;
		evt_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		src_idle_pct = 15;
		snk_idle_pct = 72;
		push_item(KIND_BYTE, 8'h00);
		push_item(KIND_BYTE, 8'hFF);
		push_item(KIND_TICK, 8'h00);
		push_frame(8'hA5, 16'd2, 1'b1, 8'h00, -1, 0, 0);
		push_frame(8'hFF, 16'd0, 1'b0, -1, -1, 0, 0);
		push_frame(8'h00, 16'h0101, 1'b1, -1, -1, 0, 0);
		hold_next = 1'b1;
		push_frame(8'h3C, 16'd0, 1'b1, -1, -1, 2, 2);
		drain();

		write_reg(CFG_MAX_PAYLOAD, 16'd16);
		write_reg(CFG_TIMEOUT, 16'd3);
		push_random(200);
		drain();

		src_idle_pct = 72;
		snk_idle_pct = 15;
		write_reg(CFG_NO_REG, 16'h0000);
		write_reg(CFG_MAX_PAYLOAD, 16'd0);
		write_reg(CFG_TIMEOUT, 16'd0);
		hold_next = 1'b1;
		push_frame(8'h81, 16'd0, 1'b1, -1, -1, 0, 0);
		push_frame(8'h18, 16'd1, 1'b1, -1, -1, 0, 0);
		push_item(KIND_BYTE, MAGIC_BYTE);
		push_item(KIND_TICK, 8'hAA);
		push_item(KIND_BYTE, 8'h55);
		push_random(200);
		drain();

		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_reg(CFG_MAX_PAYLOAD, 16'hFFFF);
		write_reg(CFG_TIMEOUT, 16'd1);
		push_frame(8'h7E, 16'hFFFF, 1'b1, -1, 6, 0, 0);
		repeat (3) push_item(KIND_TICK, 8'h00);
		push_item(KIND_BYTE, 8'h00);
		push_random(200);
		drain();

		write_reg(CFG_MAX_PAYLOAD, 16'd300);
		write_reg(CFG_TIMEOUT, 16'hFFFF);
		push_random(200);
		drain();

		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
